// ----- src/hufd_pkg.sv -----
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types and constants for the Huffman tree decoder: operation codes,
// result status codes, the controller state type and symbol conventions.
// ----------------------------------------------------------------------------
package hufd_pkg;

	// Width of one symbol.
	localparam int SYM_W = 8;

	// Operation codes carried in the input tuser.
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_DECODE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// Result status codes carried in the output tuser.
	localparam logic [2:0] ST_SYMBOL   = 3'd0;
	localparam logic [2:0] ST_END      = 3'd1;
	localparam logic [2:0] ST_MISSING  = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_CONFLICT = 3'd4;

	// The inner-node mark and the end-of-text symbol.
	localparam logic [SYM_W-1:0] INNER_SYMBOL = 8'd0;
	localparam logic [SYM_W-1:0] END_SYMBOL   = 8'd3;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC_RD,
		S_LD_STEP,
		S_LD_NEW,
		S_LD_RD,
		S_HOLD
	} hufd_state_t;

endpackage

// ----- src/hufd_ram.sv -----
// ----------------------------------------------------------------------------
// hufd_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered when the read is enabled.
// ----------------------------------------------------------------------------
module hufd_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- src/huffman_tree_decoder.sv -----
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// Bit-serial Huffman decoder over a loadable code tree. Inner and leaf nodes
// live in a node RAM; the root node is kept in flip-flops.
//
//   Channel  Dir  Handshake                     Content
//   s_axis   in   s_axis_tvalid/s_axis_tready   tuser: op; tdata: load/decode
//   m_axis   out  m_axis_tvalid/m_axis_tready   tuser: status; tdata: symbol
//
// A decode bit is accepted, then the node RAM read of the child comes back;
// a missing branch or an ignored bit is done at acceptance. A load is
// accepted, then walks the code bits in turn, each with either a RAM read of
// an existing child, or a parent link write followed by the new node write.
// A clear is done at acceptance. Reset needs no clearing pass: the root is in
// flip-flops and no link ever points at an unwritten RAM entry.
// An output register parts the sides; a stalled result holds the controller
// only once a second result is ready.
// ----------------------------------------------------------------------------
module huffman_tree_decoder
	import hufd_pkg::*;
#(
	parameter int NODE_COUNT   = 512,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input beat.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // sym[7:0], code_word[39:8], code_length[45:40],
	                                   // code_bit[46], zero[47]
	input  logic [1:0]  s_axis_tuser,  // op[1:0]
	// Result beat.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // decoded_symbol[7:0]
	output logic [2:0]  m_axis_tuser   // status[2:0]
);

	localparam int NW = $clog2(NODE_COUNT);
	localparam int FW = NW + 1;
	localparam int PW = $clog2(MAX_CODE_LEN + 1);
	localparam int EW = SYM_W + 2 * NW;

	// Input fields.
	logic [1:0]       in_op;
	logic [SYM_W-1:0] in_sym;
	logic [31:0]      in_word;
	logic [5:0]       in_len;
	logic             in_bit;

	assign in_op   = s_axis_tuser;
	assign in_sym  = s_axis_tdata[7:0];
	assign in_word = s_axis_tdata[39:8];
	assign in_len  = s_axis_tdata[45:40];
	assign in_bit  = s_axis_tdata[46];

	// Registers.
	hufd_state_t      state_q, state_d;
	logic [NW-1:0]    root_l0_q, root_l0_d, root_l1_q, root_l1_d;
	logic [NW-1:0]    cur_idx_q, cur_idx_d;
	logic [NW-1:0]    cur_l0_q, cur_l0_d, cur_l1_q, cur_l1_d;
	logic [FW-1:0]    free_q, free_d;
	logic             done_q, done_d;
	logic [NW-1:0]    ld_node_q, ld_node_d;
	logic [NW-1:0]    ld_l0_q, ld_l0_d, ld_l1_q, ld_l1_d;
	logic [PW-1:0]    ld_pos_q, ld_pos_d;
	logic [SYM_W-1:0] ld_sym_q, ld_sym_d;
	logic [31:0]      ld_word_q, ld_word_d;
	logic [NW-1:0]    child_q, child_d;
	logic             out_valid_q, out_valid_d;
	logic [SYM_W-1:0] out_sym_q, out_sym_d, pend_sym_q, pend_sym_d;
	logic [2:0]       out_st_q, out_st_d, pend_st_q, pend_st_d;

	// Node RAM ports.
	logic             wr_en;
	logic [NW-1:0]    wr_addr;
	logic [EW-1:0]    wr_data;
	logic             rd_en;
	logic [NW-1:0]    rd_addr;
	logic [EW-1:0]    rd_data;
	logic [SYM_W-1:0] rd_sym;
	logic [NW-1:0]    rd_l0, rd_l1;

	// Node entry layout: symbol at the top, then link 1, then link 0.
	assign rd_sym = rd_data[EW-1 -: SYM_W];
	assign rd_l1  = rd_data[2*NW-1 -: NW];
	assign rd_l0  = rd_data[NW-1:0];

	hufd_ram #(
		.WIDTH (EW),
		.DEPTH (NODE_COUNT)
	) u_node_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Helper terms.
	logic          out_free;
	logic          table_full;
	logic [NW-1:0] dec_child;
	logic [6:0]    ld_pm1;
	logic          ld_bit;
	logic          ld_last;
	logic [NW-1:0] ld_child;
	logic [NW-1:0] new_node;
	logic          emit_req;
	logic [SYM_W-1:0] emit_sym;
	logic [2:0]    emit_st;

	assign out_free   = !out_valid_q || m_axis_tready;
	assign table_full = (free_q == FW'(NODE_COUNT));
	assign new_node   = free_q[NW-1:0];

	// Link of the current decode node selected by the stream bit.
	always_comb begin
		if (cur_idx_q == '0) begin
			dec_child = in_bit ? root_l1_q : root_l0_q;
		end else begin
			dec_child = in_bit ? cur_l1_q : cur_l0_q;
		end
	end

	// Code bit at position pos-1; bits above bit 31 read as zero.
	assign ld_pm1   = 7'(ld_pos_q) - 7'd1;
	assign ld_bit   = (ld_pm1[6:5] == 2'b00) ? ld_word_q[ld_pm1[4:0]] : 1'b0;
	assign ld_last  = (ld_pos_q == PW'(1));
	assign ld_child = ld_bit ? ld_l1_q : ld_l0_q;

	assign s_axis_tready = (state_q == S_IDLE);

	// Next state, RAM accesses and results.
	always_comb begin
		state_d     = state_q;
		root_l0_d   = root_l0_q;
		root_l1_d   = root_l1_q;
		cur_idx_d   = cur_idx_q;
		cur_l0_d    = cur_l0_q;
		cur_l1_d    = cur_l1_q;
		free_d      = free_q;
		done_d      = done_q;
		ld_node_d   = ld_node_q;
		ld_l0_d     = ld_l0_q;
		ld_l1_d     = ld_l1_q;
		ld_pos_d    = ld_pos_q;
		ld_sym_d    = ld_sym_q;
		ld_word_d   = ld_word_q;
		child_d     = child_q;
		pend_sym_d  = pend_sym_q;
		pend_st_d   = pend_st_q;
		out_valid_d = out_valid_q && !m_axis_tready;
		out_sym_d   = out_sym_q;
		out_st_d    = out_st_q;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = '0;
		rd_en       = 1'b0;
		rd_addr     = '0;
		emit_req    = 1'b0;
		emit_sym    = INNER_SYMBOL;
		emit_st     = ST_SYMBOL;

		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					case (in_op)
						OP_LOAD: begin
							if (in_len == '0 || in_sym == INNER_SYMBOL ||
							    7'(in_len) > 7'(MAX_CODE_LEN)) begin
								emit_req = 1'b1;
								emit_st  = ST_CONFLICT;
							end else begin
								ld_node_d = '0;
								ld_l0_d   = root_l0_q;
								ld_l1_d   = root_l1_q;
								ld_pos_d  = PW'(in_len);
								ld_sym_d  = in_sym;
								ld_word_d = in_word;
								state_d   = S_LD_STEP;
							end
						end
						OP_DECODE: begin
							if (!done_q) begin
								if (dec_child == '0) begin
									cur_idx_d = '0;
									emit_req  = 1'b1;
									emit_st   = ST_MISSING;
								end else begin
									rd_en   = 1'b1;
									rd_addr = dec_child;
									child_d = dec_child;
									state_d = S_DEC_RD;
								end
							end
						end
						OP_CLEAR: begin
							root_l0_d = '0;
							root_l1_d = '0;
							cur_idx_d = '0;
							free_d    = FW'(1);
							done_d    = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end

			// Child node read back: a leaf ends the symbol, an inner node
			// becomes the current node.
			S_DEC_RD: begin
				state_d = S_IDLE;
				if (rd_sym != INNER_SYMBOL) begin
					cur_idx_d = '0;
					emit_req  = 1'b1;
					emit_sym  = rd_sym;
					if (rd_sym == END_SYMBOL) begin
						done_d  = 1'b1;
						emit_st = ST_END;
					end else begin
						emit_st = ST_SYMBOL;
					end
				end else begin
					cur_idx_d = child_q;
					cur_l0_d  = rd_l0;
					cur_l1_d  = rd_l1;
				end
			end

			// One code bit of a load walk.
			S_LD_STEP: begin
				if (ld_last && ld_child != '0) begin
					emit_req = 1'b1;
					emit_st  = ST_CONFLICT;
					state_d  = S_IDLE;
				end else if (ld_child == '0) begin
					if (table_full) begin
						emit_req = 1'b1;
						emit_st  = ST_FULL;
						state_d  = S_IDLE;
					end else begin
						// Link the parent to the new node.
						if (ld_node_q == '0) begin
							if (ld_bit) begin
								root_l1_d = new_node;
							end else begin
								root_l0_d = new_node;
							end
						end else begin
							wr_en   = 1'b1;
							wr_addr = ld_node_q;
							wr_data = {INNER_SYMBOL, ld_bit ? new_node : ld_l1_q,
							           ld_bit ? ld_l0_q : new_node};
							// Keep the cached decode node coherent.
							if (ld_node_q == cur_idx_q) begin
								if (ld_bit) begin
									cur_l1_d = new_node;
								end else begin
									cur_l0_d = new_node;
								end
							end
						end
						child_d = new_node;
						state_d = S_LD_NEW;
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = ld_child;
					child_d = ld_child;
					state_d = S_LD_RD;
				end
			end

			// Write the freshly allocated node: a leaf at the last bit.
			S_LD_NEW: begin
				wr_en   = 1'b1;
				wr_addr = child_q;
				wr_data = {ld_last ? ld_sym_q : INNER_SYMBOL, {(2*NW){1'b0}}};
				free_d  = free_q + FW'(1);
				if (ld_last) begin
					state_d = S_IDLE;
				end else begin
					ld_node_d = child_q;
					ld_l0_d   = '0;
					ld_l1_d   = '0;
					ld_pos_d  = ld_pos_q - PW'(1);
					state_d   = S_LD_STEP;
				end
			end

			// Existing child read back: it must be an inner node.
			S_LD_RD: begin
				if (rd_sym != INNER_SYMBOL) begin
					emit_req = 1'b1;
					emit_st  = ST_CONFLICT;
					state_d  = S_IDLE;
				end else begin
					ld_node_d = child_q;
					ld_l0_d   = rd_l0;
					ld_l1_d   = rd_l1;
					ld_pos_d  = ld_pos_q - PW'(1);
					state_d   = S_LD_STEP;
				end
			end

			// A result waits for the output register to free up.
			S_HOLD: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_sym_d   = pend_sym_q;
					out_st_d    = pend_st_q;
					state_d     = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Hand a result to the output register, or park it.
		if (emit_req) begin
			if (out_free) begin
				out_valid_d = 1'b1;
				out_sym_d   = emit_sym;
				out_st_d    = emit_st;
			end else begin
				pend_sym_d = emit_sym;
				pend_st_d  = emit_st;
				state_d    = S_HOLD;
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			root_l0_q   <= '0;
			root_l1_q   <= '0;
			cur_idx_q   <= '0;
			free_q      <= FW'(1);
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			root_l0_q   <= root_l0_d;
			root_l1_q   <= root_l1_d;
			cur_idx_q   <= cur_idx_d;
			free_q      <= free_d;
			done_q      <= done_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload and walk registers.
	always_ff @(posedge clk) begin
		cur_l0_q   <= cur_l0_d;
		cur_l1_q   <= cur_l1_d;
		ld_node_q  <= ld_node_d;
		ld_l0_q    <= ld_l0_d;
		ld_l1_q    <= ld_l1_d;
		ld_pos_q   <= ld_pos_d;
		ld_sym_q   <= ld_sym_d;
		ld_word_q  <= ld_word_d;
		child_q    <= child_d;
		pend_sym_q <= pend_sym_d;
		pend_st_q  <= pend_st_d;
		out_sym_q  <= out_sym_d;
		out_st_q   <= out_st_d;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_sym_q;
	assign m_axis_tuser  = out_st_q;

`ifndef SYNTHESIS
	// The allocation pointer stays between one and the table size.
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q >= FW'(1) && free_q <= FW'(NODE_COUNT))
		else $error("free node pointer out of range");

	// The current decode node is always an allocated node.
	a_cur_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		FW'(cur_idx_q) < free_q)
		else $error("current node beyond allocated nodes");

	// RAM reads only touch allocated non-root nodes.
	a_rd_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (rd_addr != '0 && FW'(rd_addr) < free_q))
		else $error("node RAM read of an unallocated entry");

	// RAM writes never touch the root and never pass the allocation pointer.
	a_wr_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_addr != '0 && FW'(wr_addr) <= free_q))
		else $error("node RAM write outside the allocated range");

	// A parked result only exists while the output register is occupied.
	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD) |-> out_valid_q)
		else $error("result parked while output register is free");
`endif

endmodule
